>>> rtl/ggs_pkg.sv
package ggs_pkg;

  typedef enum logic [1:0] {
    OP_WR_SRC = 2'd0,
    OP_WR_SOL = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_DONE    = 2'd1,
    ST_RDATA   = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_GRID_SIZE = 3'd0,
    REG_COEF_NBR  = 3'd1,
    REG_COEF_DIV  = 3'd2,
    REG_BORDER    = 3'd3,
    REG_SWEEPS    = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SW_INIT,
    S_IN_RD,
    S_IN_MUL,
    S_IN_DIV,
    S_IN_WR,
    S_BD_RD,
    S_BD_WAIT,
    S_BD_WR,
    S_RESP
  } state_e;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned GS_BITS       = 6;
  localparam int unsigned COEF_BITS     = 31;
  localparam int unsigned SWEEP_BITS    = 8;
  localparam int unsigned OP_BITS       = 2;
  localparam int unsigned IDX_BITS      = 12;
  localparam int unsigned VAL_BITS      = 32;
  localparam int unsigned STATUS_BITS   = 2;

endpackage

>>> rtl/ggs_if.sv
interface ggs_in_if;
  import ggs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      op;
  logic [IDX_BITS-1:0]     cell_index;
  logic signed [VAL_BITS-1:0] cell_value;
  modport source (output valid, op, cell_index, cell_value, input ready);
  modport sink (input valid, op, cell_index, cell_value, output ready);
endinterface

interface ggs_out_if;
  import ggs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VAL_BITS-1:0] read_value;
  logic [STATUS_BITS-1:0]     status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

interface ggs_cfg_if;
  import ggs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/grid_gauss_seidel_relaxation.sv
// Loads and reads: one memory access plus the result register per item.
// Solve: per sweep N*N inner updates through S_IN_RD, S_IN_MUL, S_IN_DIV and S_IN_WR, the
// divide done by the bit-serial divider, then 4N + 4 border updates through S_BD_RD, S_BD_WAIT and S_BD_WR.
// Throughput: one item at a time; the next item is taken once the result is accepted.
// Reset clears control and loads the register reset values; grid memories are not cleared.
module grid_gauss_seidel_relaxation #(
  parameter int unsigned MAX_GRID_CELLS = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  ggs_in_if.sink    in_i,
  ggs_out_if.source out_o,
  ggs_cfg_if.sink   cfg_i
);
  import ggs_pkg::*;

  function automatic int unsigned max_inner(input int unsigned cells);
    int unsigned n;
    n = 63;
    while (n > 1 && (n + 2) * (n + 2) > cells) n--;
    return n;
  endfunction

  localparam int unsigned AW    = $clog2(MAX_GRID_CELLS);
  localparam int unsigned VB    = VAL_BITS;
  localparam int unsigned NB    = 96;
  localparam int unsigned NMAX  = max_inner(MAX_GRID_CELLS);
  localparam int unsigned PW    = 2 * VB + 1;

  logic signed [VB-1:0] vmax, vmin;
  assign vmax = {1'b0, {(VB-1){1'b1}}};
  assign vmin = {1'b1, {(VB-1){1'b0}}};

  logic [GS_BITS-1:0]    grid_size_q;
  logic [COEF_BITS-1:0]  coef_a_q, coef_c_q;
  logic [1:0]            border_q;
  logic [SWEEP_BITS-1:0] sweeps_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GS_BITS'(62);
      coef_a_q    <= COEF_BITS'(65536);
      coef_c_q    <= COEF_BITS'(262144);
      border_q    <= 2'd0;
      sweeps_q    <= SWEEP_BITS'(20);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GRID_SIZE: grid_size_q <= cfg_i.data[GS_BITS-1:0];
        REG_COEF_NBR:  coef_a_q    <= cfg_i.data[COEF_BITS-1:0];
        REG_COEF_DIV:  coef_c_q    <= cfg_i.data[COEF_BITS-1:0];
        REG_BORDER:    border_q    <= cfg_i.data[1:0];
        REG_SWEEPS:    sweeps_q    <= cfg_i.data[SWEEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective inner size: zero acts as one, capped so that (n+2)^2 fits
  logic [6:0] n_gs, n_eff;
  assign n_gs  = (grid_size_q == '0) ? 7'd1 : {1'b0, grid_size_q};
  assign n_eff = (n_gs > 7'(NMAX)) ? 7'(NMAX) : n_gs;
  logic [6:0]  w_eff;
  logic [13:0] ww;
  assign w_eff = n_eff + 7'd2;
  assign ww    = 14'(w_eff) * 14'(w_eff);

  logic [COEF_BITS-1:0] c_eff;
  assign c_eff = (coef_c_q < COEF_BITS'(65536)) ? COEF_BITS'(65536) : coef_c_q;

  function automatic logic signed [VB-1:0] sat(input logic signed [PW:0] v,
                                               input logic signed [VB-1:0] hi,
                                               input logic signed [VB-1:0] lo);
    if (v > (PW+1)'(hi)) return hi;
    if (v < $signed((PW+1)'(lo))) return lo;
    return v[VB-1:0];
  endfunction

  // memories
  logic          sol_we, src_we;
  logic [AW-1:0] sol_wa, src_wa, sol_ra, src_ra;
  logic [VB-1:0] sol_wd, src_wd, sol_rd, src_rd;

  ggs_ram #(.Width(VB), .Depth(MAX_GRID_CELLS)) u_sol (
    .clk_i, .we_i(sol_we), .waddr_i(sol_wa), .wdata_i(sol_wd),
    .raddr_i(sol_ra), .rdata_o(sol_rd));
  ggs_ram #(.Width(VB), .Depth(MAX_GRID_CELLS)) u_src (
    .clk_i, .we_i(src_we), .waddr_i(src_wa), .wdata_i(src_wd),
    .raddr_i(src_ra), .rdata_o(src_rd));

  // control
  state_e state_q, state_d;
  logic [SWEEP_BITS-1:0] sw_q, sw_d;
  logic [6:0]  ci_q, ci_d, cj_q, cj_d;
  logic [2:0]  rc_q, rc_d;
  logic [7:0]  bk_q, bk_d;
  logic signed [PW:0] acc_q, acc_d;
  logic signed [VB-1:0] t0_q, t0_d, src_q, src_d;
  logic [NB-1:0] num_q, num_d;
  logic        num_neg_q, num_neg_d;
  logic signed [VB-1:0] res_val_q, res_val_d;
  logic [STATUS_BITS-1:0] res_st_q, res_st_d;
  logic        out_v_q, out_v_d;
  logic        div_start, div_busy;
  logic [NB-1:0] div_q;

  ggs_div #(.NumBits(NB), .DenBits(COEF_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(c_eff),
    .busy_o(div_busy), .quot_o(div_q));

  logic [13:0] pidx;
  assign pidx = 14'(ci_q) + 14'(w_eff) * 14'(cj_q);

  // border address plan: bk 0..2n-1 top/bottom row pairs, 2n..4n-1 left/right column pairs, 4n..4n+3 corners
  logic [13:0] b_src, b_dst, b_src2;
  logic        b_corner, b_neg;
  logic [6:0]  kk;
  logic [1:0]  bsel;
  logic [6:0]  nn;
  always_comb begin
    nn = n_eff;
    kk = 7'd0;
    bsel = 2'd0;
    b_src = '0; b_dst = '0; b_src2 = '0; b_corner = 1'b0; b_neg = 1'b0;
    if (bk_q < {nn, 1'b0}) begin
      kk = 7'(bk_q >> 1) + 7'd1;
      if (!bk_q[0]) begin
        b_dst = 14'(kk);
        b_src = 14'(kk) + 14'(w_eff);
      end else begin
        b_dst = 14'(kk) + 14'(w_eff) * 14'(nn + 7'd1);
        b_src = 14'(kk) + 14'(w_eff) * 14'(nn);
      end
      b_neg = (border_q == 2'd2);
    end else if (bk_q < {nn, 2'b00}) begin
      kk = 7'((bk_q - {nn, 1'b0}) >> 1) + 7'd1;
      if (!bk_q[0]) begin
        b_dst = 14'(w_eff) * 14'(kk);
        b_src = b_dst + 14'd1;
      end else begin
        b_dst = 14'(nn + 7'd1) + 14'(w_eff) * 14'(kk);
        b_src = 14'(nn) + 14'(w_eff) * 14'(kk);
      end
      b_neg = (border_q == 2'd1);
    end else begin
      b_corner = 1'b1;
      bsel = 2'(bk_q - {nn, 2'b00});
      unique case (bsel)
        2'd0: begin
          b_dst = '0; b_src = 14'd1; b_src2 = 14'(w_eff);
        end
        2'd1: begin
          b_dst = 14'(w_eff) * 14'(nn + 7'd1);
          b_src = b_dst + 14'd1; b_src2 = 14'(w_eff) * 14'(nn);
        end
        2'd2: begin
          b_dst = 14'(nn + 7'd1);
          b_src = 14'(nn); b_src2 = 14'(nn + 7'd1) + 14'(w_eff);
        end
        default: begin
          b_dst = 14'(nn + 7'd1) + 14'(w_eff) * 14'(nn + 7'd1);
          b_src = 14'(nn) + 14'(w_eff) * 14'(nn + 7'd1);
          b_src2 = 14'(nn + 7'd1) + 14'(w_eff) * 14'(nn);
        end
      endcase
    end
  end
  logic [7:0] bk_last;
  assign bk_last = 8'({nn, 2'b00}) + 8'd3;

  logic in_range;
  assign in_range = (14'(in_i.cell_index) < ww) && (32'(in_i.cell_index) < 32'(MAX_GRID_CELLS));

  logic signed [PW:0] prod;
  logic signed [PW:0] num_s;
  logic signed [VB:0] csum;
  logic signed [NB:0] qs;

  always_comb begin
    state_d = state_q;
    sw_d = sw_q; ci_d = ci_q; cj_d = cj_q; rc_d = rc_q; bk_d = bk_q;
    acc_d = acc_q; t0_d = t0_q; src_d = src_q;
    num_d = num_q; num_neg_d = num_neg_q;
    res_val_d = res_val_q; res_st_d = res_st_q; out_v_d = out_v_q;
    sol_we = 1'b0; src_we = 1'b0;
    sol_wa = AW'(in_i.cell_index); src_wa = AW'(in_i.cell_index);
    sol_wd = in_i.cell_value; src_wd = in_i.cell_value;
    sol_ra = AW'(in_i.cell_index); src_ra = AW'(pidx);
    div_start = 1'b0;
    prod = '0; num_s = '0; csum = '0; qs = '0;
    in_i.ready = 1'b0;

    if (out_v_q && out_o.ready) out_v_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = !out_v_q;
        if (in_i.valid && !out_v_q) begin
          res_val_d = '0;
          if (in_i.op == OP_SOLVE) begin
            sw_d = '0;
            state_d = S_SW_INIT;
          end else if (!in_range) begin
            res_st_d = ST_RANGE; out_v_d = 1'b1;
          end else if (in_i.op == OP_WR_SRC) begin
            src_we = 1'b1; res_st_d = ST_WRITTEN; out_v_d = 1'b1;
          end else if (in_i.op == OP_WR_SOL) begin
            sol_we = 1'b1; res_st_d = ST_WRITTEN; out_v_d = 1'b1;
          end else begin
            state_d = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        res_val_d = sol_rd; res_st_d = ST_RDATA; out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SW_INIT: begin
        if (sw_q == sweeps_q) begin
          state_d = S_RESP;
        end else begin
          ci_d = 7'd1; cj_d = 7'd1; rc_d = '0; acc_d = '0;
          state_d = S_IN_RD;
        end
      end
      S_IN_RD: begin
        // issue reads of four neighbours then source; accumulate each read in the next cycle
        unique case (rc_q)
          3'd0: sol_ra = AW'(pidx - 14'd1);
          3'd1: sol_ra = AW'(pidx + 14'd1);
          3'd2: sol_ra = AW'(pidx - 14'(w_eff));
          default: sol_ra = AW'(pidx + 14'(w_eff));
        endcase
        src_ra = AW'(pidx);
        if (rc_q != 3'd0) acc_d = acc_q + (PW+1)'($signed(sol_rd));
        if (rc_q == 3'd4) begin
          src_d = src_rd;
          state_d = S_IN_MUL;
        end
        rc_d = rc_q + 3'd1;
      end
      S_IN_MUL: begin
        t0_d = sat(acc_q, vmax, vmin);
        state_d = S_IN_DIV;
        rc_d = '0;
      end
      S_IN_DIV: begin
        if (rc_q == 3'd0) begin
          prod = $signed({1'b0, coef_a_q}) * $signed(t0_q);
          num_s = ((PW+1)'($signed(src_q)) <<< 16) + prod;
          num_neg_d = num_s[PW];
          num_d = num_s[PW] ? NB'(-num_s) : NB'(num_s);
          rc_d = 3'd1;
        end else if (rc_q == 3'd1) begin
          div_start = 1'b1;
          rc_d = 3'd2;
        end else if (rc_q == 3'd2) begin
          rc_d = 3'd3;
        end else if (!div_busy) begin
          state_d = S_IN_WR;
        end
      end
      S_IN_WR: begin
        qs = num_neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        sol_we = 1'b1;
        sol_wa = AW'(pidx);
        if (qs > (NB+1)'(vmax)) sol_wd = vmax;
        else if (qs < $signed((NB+1)'(vmin))) sol_wd = vmin;
        else sol_wd = qs[VB-1:0];
        rc_d = '0; acc_d = '0;
        if (cj_q == n_eff) begin
          cj_d = 7'd1;
          if (ci_q == n_eff) begin
            bk_d = '0;
            state_d = S_BD_RD;
          end else begin
            ci_d = ci_q + 7'd1;
            state_d = S_IN_RD;
          end
        end else begin
          cj_d = cj_q + 7'd1;
          state_d = S_IN_RD;
        end
      end
      S_BD_RD: begin
        sol_ra = AW'(b_src);
        state_d = S_BD_WAIT;
      end
      S_BD_WAIT: begin
        sol_ra = AW'(b_src2);
        t0_d = sol_rd;
        state_d = S_BD_WR;
      end
      S_BD_WR: begin
        sol_we = 1'b1;
        sol_wa = AW'(b_dst);
        if (b_corner) begin
          csum = (VB+1)'(t0_q) + (VB+1)'($signed(sol_rd));
          sol_wd = VB'((csum + ((csum < 0) ? (VB+1)'(1) : (VB+1)'(0))) >>> 1);
        end else if (b_neg) begin
          sol_wd = (t0_q == vmin) ? vmax : -t0_q;
        end else begin
          sol_wd = t0_q;
        end
        if (bk_q == bk_last) begin
          sw_d = sw_q + 1'b1;
          state_d = S_SW_INIT;
        end else begin
          bk_d = bk_q + 8'd1;
          state_d = S_BD_RD;
        end
      end
      S_RESP: begin
        res_st_d = ST_DONE; out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      sw_q <= '0; ci_q <= '0; cj_q <= '0; rc_q <= '0; bk_q <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      sw_q <= sw_d; ci_q <= ci_d; cj_q <= cj_d; rc_q <= rc_d; bk_q <= bk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; t0_q <= t0_d; src_q <= src_d;
    num_q <= num_d; num_neg_q <= num_neg_d;
    res_val_q <= res_val_d; res_st_q <= res_st_d;
  end

  assign out_o.valid      = out_v_q;
  assign out_o.read_value = res_val_q;
  assign out_o.status     = res_st_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid) else $error("result lost");
  a_done_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_RDATA) |-> (out_o.read_value == '0))
    else $error("nonzero value");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IN_DIV) |-> !sol_we) else $error("write during divide");
endmodule

>>> rtl/ggs_ram.sv
module ggs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/ggs_div.sv
module ggs_div #(
  parameter int unsigned NumBits = 96,
  parameter int unsigned DenBits = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               busy_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DenBits+1:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[NumBits-1]} - {2'b00, den_q};
      if (!trial[DenBits+1]) begin
        rem_d  = trial[DenBits:0];
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

>>> tb/tb_grid_gauss_seidel_relaxation.sv
`timescale 1ns / 100ps

module tb_grid_gauss_seidel_relaxation;
  import ggs_pkg::*;

  localparam int unsigned CELLS = 4096;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int unsigned LIMIT = 20000000;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] value;
    status_e                    status;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ggs_in_if  in_if();
  ggs_out_if out_if();
  ggs_cfg_if cfg_if();

  grid_gauss_seidel_relaxation dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always #10 clk_i = ~clk_i;

  longint     sol_grid [CELLS];
  longint     src_grid [CELLS];
  logic [5:0]  grid_size_q;
  logic [30:0] coef_nbr_q;
  logic [30:0] coef_div_q;
  logic [1:0]  border_q;
  logic [7:0]  sweeps_q;

  reply_t      replies_due[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned stall_left = 0;

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic int unsigned inner_n();
    int unsigned n;
    n = grid_size_q;
    if (n == 0) n = 1;
    while (n > 1 && (n + 2) * (n + 2) > CELLS) n--;
    return n;
  endfunction

  function automatic longint border_val(longint v, bit neg);
    return neg ? sat(-v) : v;
  endfunction

  function automatic void relax_grid();
    int unsigned n, w, p;
    longint a, c, sum, num;
    bit negrow, negcol;
    n = inner_n();
    w = n + 2;
    a = coef_nbr_q;
    c = coef_div_q;
    if (c < 65536) c = 65536;
    negrow = (border_q == 2'd2);
    negcol = (border_q == 2'd1);
    for (int s = 0; s < sweeps_q; s++) begin
      for (int i = 1; i <= n; i++) begin
        for (int j = 1; j <= n; j++) begin
          p = i + w * j;
          sum = sat(sol_grid[p-1] + sol_grid[p+1] + sol_grid[p-w] + sol_grid[p+w]);
          num = src_grid[p] * 65536 + a * sum;
          sol_grid[p] = sat(num / c);
        end
      end
      for (int k = 1; k <= n; k++) begin
        sol_grid[k] = border_val(sol_grid[k+w], negrow);
        sol_grid[k+w*(n+1)] = border_val(sol_grid[k+w*n], negrow);
      end
      for (int k = 1; k <= n; k++) begin
        sol_grid[w*k] = border_val(sol_grid[1+w*k], negcol);
        sol_grid[(n+1)+w*k] = border_val(sol_grid[n+w*k], negcol);
      end
      sol_grid[0] = (sol_grid[1] + sol_grid[w]) / 2;
      sol_grid[w*(n+1)] = (sol_grid[1+w*(n+1)] + sol_grid[w*n]) / 2;
      sol_grid[n+1] = (sol_grid[n] + sol_grid[(n+1)+w]) / 2;
      sol_grid[(n+1)+w*(n+1)] = (sol_grid[n+w*(n+1)] + sol_grid[(n+1)+w*n]) / 2;
    end
  endfunction

  function automatic reply_t apply_item(op_e op, int unsigned idx, logic [31:0] raw);
    reply_t r;
    int unsigned w;
    w = inner_n() + 2;
    r.value = '0;
    if (op == OP_SOLVE) begin
      relax_grid();
      r.status = ST_DONE;
    end else if (idx >= w * w) begin
      r.status = ST_RANGE;
    end else if (op == OP_WR_SRC) begin
      src_grid[idx] = longint'($signed(raw));
      r.status = ST_WRITTEN;
    end else if (op == OP_WR_SOL) begin
      sol_grid[idx] = longint'($signed(raw));
      r.status = ST_WRITTEN;
    end else begin
      r.value = sol_grid[idx][31:0];
      r.status = ST_RDATA;
    end
    return r;
  endfunction

  task automatic send_item(op_e op, int unsigned idx, logic [31:0] raw);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.cell_index <= idx[11:0];
    in_if.cell_value <= raw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    replies_due.push_back(apply_item(op, idx, raw));
    items_sent++;
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    in_if.valid  <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_GRID_SIZE: grid_size_q = data[5:0];
      REG_COEF_NBR:  coef_nbr_q  = data[30:0];
      REG_COEF_DIV:  coef_div_q  = data[30:0];
      REG_BORDER:    border_q    = data[1:0];
      REG_SWEEPS:    sweeps_q    = data[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  task automatic load_all_cells();
    int unsigned w;
    w = inner_n() + 2;
    for (int unsigned k = 0; k < w * w; k++) begin
      send_item(OP_WR_SRC, k, pick_value());
      send_item(OP_WR_SOL, k, pick_value());
    end
  endtask

  task automatic test_large_grid();
    write_reg(REG_GRID_SIZE, 32'd63);
    send_item(OP_WR_SRC, 4095, 32'h7FFF_FFFF);
    send_item(OP_WR_SOL, 0, 32'h8000_0000);
    send_item(OP_WR_SOL, 4095, 32'h7FFF_FFFF);
    send_item(OP_WR_SOL, 2730, 32'hAAAA_AAAA);
    send_item(OP_WR_SOL, 1365, 32'h5555_5555);
    send_item(OP_READ, 0, 32'h0);
    send_item(OP_READ, 4095, 32'h0);
    send_item(OP_READ, 2730, 32'hFFFF_FFFF);
    send_item(OP_READ, 1365, 32'h0);
  endtask

  task automatic test_tiny_grid();
    write_reg(REG_GRID_SIZE, 32'd0);
    write_reg(REG_COEF_NBR, 32'hFFFF_FFFF);
    write_reg(REG_COEF_DIV, 32'd0);
    write_reg(REG_BORDER, 32'd3);
    write_reg(REG_SWEEPS, 32'd0);
    load_all_cells();
    send_item(OP_SOLVE, 0, 32'h0);
    send_item(OP_READ, 4, 32'h0);
    send_item(OP_READ, 9, 32'h0);
    send_item(OP_WR_SOL, 4095, 32'h1234_5678);
    write_reg(REG_SWEEPS, 32'd1);
    send_item(OP_SOLVE, 0, 32'h0);
    for (int unsigned k = 0; k < 9; k++) send_item(OP_READ, k, 32'h0);
  endtask

  task automatic random_phase();
    int unsigned w, n, pick, idx;
    write_reg(REG_GRID_SIZE, $urandom_range(0, 5));
    n = inner_n();
    case ($urandom_range(0, 4))
      0: write_reg(REG_COEF_NBR, 32'd0);
      1: write_reg(REG_COEF_NBR, 32'h7FFF_FFFF);
      2: write_reg(REG_COEF_NBR, $urandom);
      default: write_reg(REG_COEF_NBR, $urandom_range(0, 32'h0002_0000));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(REG_COEF_DIV, $urandom_range(0, 65535));
      1: write_reg(REG_COEF_DIV, 32'h7FFF_FFFF);
      2: write_reg(REG_COEF_DIV, $urandom);
      default: write_reg(REG_COEF_DIV, $urandom_range(65536, 32'h0008_0000));
    endcase
    write_reg(REG_BORDER, $urandom_range(0, 3));
    if (n == 1 && $urandom_range(0, 2) == 0) write_reg(REG_SWEEPS, 32'd255);
    else write_reg(REG_SWEEPS, $urandom_range(0, 3));
    w = n + 2;
    load_all_cells();
    repeat (60) begin
      pick = $urandom_range(0, 19);
      idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, w*w-1);
      if (pick < 8) send_item(OP_READ, idx, $urandom);
      else if (pick < 12) send_item(OP_WR_SRC, idx, pick_value());
      else if (pick < 17) send_item(OP_WR_SOL, idx, pick_value());
      else if (pick == 17) send_item(OP_SOLVE, $urandom_range(0, 4095), $urandom);
      else send_item(OP_READ, $urandom_range(w*w, 4095), 32'h0);
    end
    send_item(OP_SOLVE, 0, 32'h0);
    for (int unsigned k = 0; k < w * w; k++) send_item(OP_READ, k, 32'h0);
  endtask

  task automatic test_random();
    while (items_sent < 1450) begin
      if (items_sent > 1250) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      random_phase();
    end
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    reply_t exp_r;
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stalls_on && rst_ni && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_if.read_value, out_if.status);
      end else begin
        exp_r = replies_due.pop_front();
        if (out_if.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_if.status);
        end
        if (out_if.read_value !== exp_r.value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time, exp_r.value,
                   out_if.read_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_grid_gauss_seidel_relaxation: errors");
      $finish;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.op         = OP_WR_SRC;
    in_if.cell_index = '0;
    in_if.cell_value = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_GRID_SIZE;
    cfg_if.data      = '0;
    grid_size_q = 6'd62;
    coef_nbr_q  = 31'd65536;
    coef_div_q  = 31'd262144;
    border_q    = 2'd0;
    sweeps_q    = 8'd20;
    for (int k = 0; k < CELLS; k++) begin
      sol_grid[k] = 0;
      src_grid[k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_large_grid();
    test_tiny_grid();
    test_random();
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_grid_gauss_seidel_relaxation: clean");
    end else begin
      $display("tb_grid_gauss_seidel_relaxation: errors");
    end
    $finish;
  end

endmodule
